// ===== rtl/mm3_pkg.sv =====
// Shared constants, types and helper functions of the streaming 128-bit hash.
`default_nettype none
package mm3_pkg;

	localparam int LENGTH_BITS = 31;
	localparam int COUNT_W     = 5;
	localparam int CFG_IDX_W   = 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [COUNT_W-1:0] BLOCK_BYTES = 5'd16;

	localparam logic [63:0] MUL_A   = 64'h87c37b91114253d5;
	localparam logic [63:0] MUL_B   = 64'h4cf5ad432745937f;
	localparam logic [63:0] ADD_ONE = 64'h0000000052dce729;
	localparam logic [63:0] ADD_TWO = 64'h0000000038495ab5;
	localparam logic [63:0] FIN_A   = 64'hff51afd7ed558ccd;
	localparam logic [63:0] FIN_B   = 64'hc4ceb9fe1a85ec53;

	localparam logic [31:0] MASK_RESET = 32'd1023;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEED = 1'b0,
		REG_MASK = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [63:0]        lo;
		logic [63:0]        hi;
		logic [COUNT_W-1:0] count;
		logic               full;
		logic               has_hi;
		logic               fin;
	} item_t;

	function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned s);
		rotl64 = (v << s) | (v >> (7'd64 - 7'(s)));
	endfunction

	function automatic logic [63:0] xs33(input logic [63:0] v);
		xs33 = v ^ (v >> 33);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/mm3_ifs.sv =====
// Block, result and configuration channel interfaces.
`default_nettype none
interface mm3_blk_if;
	logic        valid;
	logic        ready;
	logic [63:0] word_low;
	logic [63:0] word_high;
	logic [4:0]  byte_count;
	logic        last;
	modport source (output valid, word_low, word_high, byte_count, last, input ready);
	modport sink (input valid, word_low, word_high, byte_count, last, output ready);
endinterface

interface mm3_res_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_low;
	logic [63:0] hash_high;
	logic [31:0] bucket_index;
	modport source (output valid, hash_low, hash_high, bucket_index, input ready);
	modport sink (input valid, hash_low, hash_high, bucket_index, output ready);
endinterface

interface mm3_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/mm3_front.sv =====
// Front end: accept blocks, clamp the count, mask unused bytes, classify.
`default_nettype none
module mm3_front
	import mm3_pkg::*;
(
	mm3_blk_if.sink     blk,
	output logic        push_valid,
	input  logic        push_ready,
	output item_t       push_item
);

	logic [COUNT_W-1:0] cnt;
	logic [7:0]         lo_en;
	logic [7:0]         hi_en;
	logic               short_blk;
	logic               keep;

	always_comb begin
		cnt = (blk.byte_count > BLOCK_BYTES) ? BLOCK_BYTES : blk.byte_count;
		for (int b = 0; b < 8; b++) begin
			lo_en[b] = COUNT_W'(b) < cnt;
			hi_en[b] = COUNT_W'(b + 8) < cnt;
		end
		for (int b = 0; b < 8; b++) begin
			push_item.lo[8*b +: 8] = blk.word_low[8*b +: 8] & {8{lo_en[b]}};
			push_item.hi[8*b +: 8] = blk.word_high[8*b +: 8] & {8{hi_en[b]}};
		end
		short_blk        = (cnt != '0) && (cnt != BLOCK_BYTES);
		push_item.count  = cnt;
		push_item.full   = (cnt == BLOCK_BYTES);
		push_item.has_hi = (cnt > 5'd8);
		push_item.fin    = blk.last | short_blk;
		keep             = (cnt != '0) | blk.last;
	end

	// drop empty non-final blocks
	assign blk.ready  = push_ready;
	assign push_valid = blk.valid & keep;

endmodule
`default_nettype wire

// ===== rtl/mm3_fifo.sv =====
// Short queue of classified blocks between front and back end.
`default_nettype none
module mm3_fifo
	import mm3_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	item_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = mem_q[rd_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_item;
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count out of range");
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_q == rd_q))
		else $error("queue pointers disagree with empty count");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |=> (cnt_q == $past(cnt_q) - 1'b1) || $past(do_push))
		else $error("queue count lost a pop");
`endif

endmodule
`default_nettype wire

// ===== rtl/mm3_back.sv =====
// Back end: lane mixing, finalization and result register over one 32x32 multiplier.
`default_nettype none
module mm3_back
	import mm3_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_valid,
	output logic     q_ready,
	input  item_t    q_item,
	mm3_cfg_if.sink  cfg,
	mm3_res_if.source res
);

	typedef enum logic [14:0] {
		S_IDLE  = 15'b000000000000001,
		S_K1A   = 15'b000000000000010,
		S_K1B   = 15'b000000000000100,
		S_MIX1  = 15'b000000000001000,
		S_MIX1B = 15'b000000000010000,
		S_K2A   = 15'b000000000100000,
		S_K2B   = 15'b000000001000000,
		S_MIX2  = 15'b000000010000000,
		S_MIX2B = 15'b000000100000000,
		S_FIN1  = 15'b000001000000000,
		S_FIN2  = 15'b000010000000000,
		S_FA    = 15'b000100000000000,
		S_FB    = 15'b001000000000000,
		S_OUT1  = 15'b010000000000000,
		S_OUT2  = 15'b100000000000000
	} state_t;

	state_t                 state_q;
	logic [1:0]             ph_q;
	logic                   sec_q;
	logic [63:0]            h1_q;
	logic [63:0]            h2_q;
	logic [LENGTH_BITS-1:0] total_q;
	logic [31:0]            seed_q;
	logic [31:0]            mask_q;
	logic                   out_valid_q;
	logic [63:0]            acc_q;
	logic [63:0]            m_q;
	item_t                  cur_q;
	logic [63:0]            hash_low_q;
	logic [63:0]            hash_high_q;
	logic [31:0]            index_q;

	logic                   is_mul;
	logic                   mul_done;
	logic [63:0]            mul_c;
	logic [31:0]            mul_a;
	logic [31:0]            mul_b;
	logic [63:0]            prod;
	logic [63:0]            mres;
	logic [63:0]            len64;
	logic [63:0]            seed64;
	logic [LENGTH_BITS:0]   len_sum;
	logic                   out_free;
	logic                   finish;

	assign is_mul = (state_q == S_K1A) || (state_q == S_K1B) || (state_q == S_K2A) ||
		(state_q == S_K2B) || (state_q == S_FA) || (state_q == S_FB);
	assign mul_done = is_mul && (ph_q == 2'd2);

	always_comb begin
		unique case (state_q)
			S_K1A, S_K2B: mul_c = MUL_A;
			S_K1B, S_K2A: mul_c = MUL_B;
			S_FA:         mul_c = FIN_A;
			S_FB:         mul_c = FIN_B;
			default:      mul_c = '0;
		endcase
	end

	// partial products, one per multiplier phase, in order: lo*lo, hi*lo, lo*hi
	assign mul_a = (ph_q == 2'd1) ? m_q[63:32] : m_q[31:0];
	assign mul_b = (ph_q == 2'd2) ? mul_c[63:32] : mul_c[31:0];
	assign prod  = 64'(mul_a) * 64'(mul_b);
	assign mres  = {acc_q[63:32] + prod[31:0], acc_q[31:0]};

	assign len64    = 64'(total_q);
	assign seed64   = 64'(seed_q);
	assign len_sum  = (LENGTH_BITS + 1)'(total_q) + (LENGTH_BITS + 1)'(q_item.count);
	assign q_ready  = (state_q == S_IDLE);
	assign out_free = !out_valid_q || res.ready;
	assign finish   = (state_q == S_OUT2) && out_free;

	assign cfg.ready        = 1'b1;
	assign res.valid        = out_valid_q;
	assign res.hash_low     = hash_low_q;
	assign res.hash_high    = hash_high_q;
	assign res.bucket_index = index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= '0;
			sec_q       <= 1'b0;
			h1_q        <= '0;
			h2_q        <= '0;
			total_q     <= '0;
			seed_q      <= '0;
			mask_q      <= MASK_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (is_mul) begin
				ph_q <= mul_done ? 2'd0 : ph_q + 2'd1;
			end
			if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						total_q <= len_sum[LENGTH_BITS] ? '1 : len_sum[LENGTH_BITS-1:0];
						state_q <= (q_item.count == '0) ? S_FIN1 : S_K1A;
					end
				end
				S_K1A: begin
					if (mul_done) begin
						state_q <= S_K1B;
					end
				end
				S_K1B: begin
					if (mul_done) begin
						h1_q <= h1_q ^ mres;
						if (cur_q.full) begin
							state_q <= S_MIX1;
						end else if (cur_q.has_hi) begin
							state_q <= S_K2A;
						end else begin
							state_q <= S_FIN1;
						end
					end
				end
				S_MIX1: begin
					h1_q    <= rotl64(h1_q, 27) + h2_q;
					state_q <= S_MIX1B;
				end
				S_MIX1B: begin
					h1_q    <= (h1_q << 2) + h1_q + ADD_ONE;
					state_q <= S_K2A;
				end
				S_K2A: begin
					if (mul_done) begin
						state_q <= S_K2B;
					end
				end
				S_K2B: begin
					if (mul_done) begin
						h2_q    <= h2_q ^ mres;
						state_q <= cur_q.full ? S_MIX2 : S_FIN1;
					end
				end
				S_MIX2: begin
					h2_q    <= rotl64(h2_q, 31) + h1_q;
					state_q <= S_MIX2B;
				end
				S_MIX2B: begin
					h2_q    <= (h2_q << 2) + h2_q + ADD_TWO;
					state_q <= cur_q.fin ? S_FIN1 : S_IDLE;
				end
				S_FIN1: begin
					h1_q    <= (h1_q ^ len64) + (h2_q ^ len64);
					h2_q    <= h2_q ^ len64;
					state_q <= S_FIN2;
				end
				S_FIN2: begin
					h2_q    <= h2_q + h1_q;
					sec_q   <= 1'b0;
					state_q <= S_FA;
				end
				S_FA: begin
					if (mul_done) begin
						state_q <= S_FB;
					end
				end
				S_FB: begin
					if (mul_done) begin
						if (!sec_q) begin
							h1_q    <= xs33(mres);
							sec_q   <= 1'b1;
							state_q <= S_FA;
						end else begin
							h2_q    <= xs33(mres);
							state_q <= S_OUT1;
						end
					end
				end
				S_OUT1: begin
					h1_q    <= h1_q + h2_q;
					state_q <= S_OUT2;
				end
				S_OUT2: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						h1_q        <= seed64;
						h2_q        <= seed64;
						total_q     <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cfg.valid) begin
				if (cfg.index == REG_SEED) begin
					seed_q  <= cfg.data;
					h1_q    <= 64'(cfg.data);
					h2_q    <= 64'(cfg.data);
					total_q <= '0;
				end else begin
					mask_q <= cfg.data;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_mul) begin
			if (ph_q == 2'd0) begin
				acc_q <= prod;
			end else begin
				acc_q[63:32] <= acc_q[63:32] + prod[31:0];
			end
		end
		unique case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					cur_q <= q_item;
					m_q   <= q_item.lo;
				end
			end
			S_K1A: begin
				if (mul_done) begin
					m_q <= rotl64(mres, 31);
				end
			end
			S_K1B: begin
				if (mul_done && !cur_q.full) begin
					m_q <= cur_q.hi;
				end
			end
			S_MIX1B: begin
				m_q <= cur_q.hi;
			end
			S_K2A: begin
				if (mul_done) begin
					m_q <= rotl64(mres, 33);
				end
			end
			S_FIN2: begin
				m_q <= xs33(h1_q);
			end
			S_FA: begin
				if (mul_done) begin
					m_q <= xs33(mres);
				end
			end
			S_FB: begin
				if (mul_done && !sec_q) begin
					m_q <= xs33(h2_q);
				end
			end
			S_OUT2: begin
				if (out_free) begin
					hash_low_q  <= h1_q;
					hash_high_q <= h2_q + h1_q;
					index_q     <= h1_q[31:0] & mask_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_phase_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!is_mul |-> (ph_q == 2'd0))
		else $error("multiplier phase active outside a multiply step");
	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> out_valid_q && (state_q == S_IDLE))
		else $error("finished hash not presented");
	a_lanes_restart: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (h1_q == h2_q) && (total_q == '0))
		else $error("lanes not reloaded after a message");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready) |=> (state_q == S_K1A) || (state_q == S_FIN1))
		else $error("block popped without starting work");
`endif

endmodule
`default_nettype wire

// ===== rtl/murmur3_128_stream_hash.sv =====
// Path: a final full block passes the queue, then lane mixing, then finalization; a
// final tail block mixes only the lanes its bytes reach (up to 8 bytes: the low lane)
// before finalization, and an empty final block goes straight to finalization.
// Throughput: the back end takes a new 16-byte block only once done with the last;
// it uses a single shared 32x32 multiplier that builds each 64-bit product from three partial products.
// Reset: arst_n clears lanes to seed 0, length to 0, bucket mask to 1023, queue empty.
`default_nettype none
module murmur3_128_stream_hash
	import mm3_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	mm3_blk_if.sink    blk,
	mm3_res_if.source  res,
	mm3_cfg_if.sink    cfg
);

	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop_ready;
	item_t pop_item;

	mm3_front u_front (
		.blk        (blk),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	mm3_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	mm3_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (pop_valid),
		.q_ready (pop_ready),
		.q_item  (pop_item),
		.cfg     (cfg),
		.res     (res)
	);

endmodule
`default_nettype wire
